// ----- sv/shef_pkg.sv -----
// Shared types and constants for the source holdoff event filter.
// No dependencies; imported by every module of the block.
package shef_pkg;

  // Protocol codes on the input port
  localparam logic [1:0] KIND_TCP   = 2'd0;
  localparam logic [1:0] KIND_UDP   = 2'd1;
  localparam logic [1:0] KIND_ICMP  = 2'd2;
  localparam logic [1:0] KIND_OTHER = 2'd3;
  localparam int unsigned PROTO_COUNT = 3;

  // Verdict codes on the result port
  localparam logic [1:0] VERDICT_LOG  = 2'd0;
  localparam logic [1:0] VERDICT_DROP = 2'd1;
  localparam logic [1:0] VERDICT_HOLD = 2'd2;

  // Configuration register indexes
  localparam logic [2:0] CFG_TCP_HOLDOFF  = 3'd0;
  localparam logic [2:0] CFG_UDP_HOLDOFF  = 3'd1;
  localparam logic [2:0] CFG_ICMP_HOLDOFF = 3'd2;
  localparam logic [2:0] CFG_LOCAL_ADDR   = 3'd3;
  localparam logic [2:0] CFG_SUBNET_MASK  = 3'd4;

  // Address constants, first octet in low byte
  localparam logic [31:0] ADDR_LIMITED_BCAST  = 32'hFFFF_FFFF;
  localparam logic [31:0] ADDR_LINK_LOCAL_BC  = 32'hFFFF_FEA9;
  localparam logic [7:0]  MCAST_FIRST_LO      = 8'd224;
  localparam logic [7:0]  MCAST_FIRST_HI      = 8'd239;

  // Holdoff seconds times 1000 fits in 26 bits
  localparam int unsigned HOLDOFF_W = 16;
  localparam int unsigned LIMIT_W   = 26;
  localparam logic [LIMIT_W-1:0] MS_PER_SEC = 26'd1000;

  // Queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  // One classified event
  typedef struct packed {
    logic               imm;      // verdict known, no table search
    logic [1:0]         verdict;  // valid when imm
    logic [1:0]         proto;
    logic [31:0]        src;
    logic [31:0]        now;
    logic [LIMIT_W-1:0] limit;    // holdoff in ms
  } shef_entry_t;

  // Back end status toward the top level
  typedef struct packed {
    logic clearing;
  } shef_back_stat_t;

endpackage

// ----- sv/shef_front.sv -----
// Front end: configuration registers and event classification.
// Depends on shef_pkg; feeds shef_queue.
module shef_front
  import shef_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic [31:0] source_addr,
  input  logic [1:0]  proto_kind,
  input  logic [31:0] now_ms,
  output shef_entry_t entry
);

  logic [HOLDOFF_W-1:0] tcp_hold_r, udp_hold_r, icmp_hold_r;
  logic [31:0]          local_addr_r, mask_r;
  logic [HOLDOFF_W-1:0] holdoff;
  logic [31:0]          subnet_bcast;
  logic                 filtered;

  // Register file, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tcp_hold_r   <= '0;
      udp_hold_r   <= '0;
      icmp_hold_r  <= '0;
      local_addr_r <= '0;
      mask_r       <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TCP_HOLDOFF:  tcp_hold_r   <= cfg_data[HOLDOFF_W-1:0];
        CFG_UDP_HOLDOFF:  udp_hold_r   <= cfg_data[HOLDOFF_W-1:0];
        CFG_ICMP_HOLDOFF: icmp_hold_r  <= cfg_data[HOLDOFF_W-1:0];
        CFG_LOCAL_ADDR:   local_addr_r <= cfg_data;
        CFG_SUBNET_MASK:  mask_r       <= cfg_data;
        default: ;
      endcase
    end
  end

  // Broadcast / multicast filter
  assign subnet_bcast = (local_addr_r & mask_r) | ~mask_r;
  assign filtered = (source_addr == ADDR_LIMITED_BCAST) ||
                    ((source_addr[7:0] >= MCAST_FIRST_LO) &&
                     (source_addr[7:0] <= MCAST_FIRST_HI)) ||
                    (source_addr == subnet_bcast) ||
                    (source_addr == ADDR_LINK_LOCAL_BC);

  // Per-protocol holdoff
  always_comb begin
    unique case (proto_kind)
      KIND_TCP:   holdoff = tcp_hold_r;
      KIND_UDP:   holdoff = udp_hold_r;
      KIND_ICMP:  holdoff = icmp_hold_r;
      KIND_OTHER: holdoff = '0;
      default:    holdoff = '0;
    endcase
  end

  // Classified beat
  always_comb begin
    entry.imm     = filtered || (holdoff == '0);
    entry.verdict = filtered ? VERDICT_DROP : VERDICT_LOG;
    entry.proto   = proto_kind;
    entry.src     = source_addr;
    entry.now     = now_ms;
    entry.limit   = LIMIT_W'(holdoff) * MS_PER_SEC;
  end

endmodule

// ----- sv/shef_queue.sv -----
// Two-entry queue of classified events between front and back.
// Depends on shef_pkg.
module shef_queue
  import shef_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  shef_entry_t push_entry,
  input  logic        pop,
  output shef_entry_t head,
  output logic        empty,
  output logic        full
);

  localparam int unsigned PW = $clog2(QUEUE_DEPTH);
  localparam int unsigned NW = $clog2(QUEUE_DEPTH + 1);

  shef_entry_t   slots_r [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [NW-1:0] count_r;

  assign empty = (count_r == '0);
  assign full  = (count_r == NW'(QUEUE_DEPTH));
  assign head  = slots_r[rd_ptr_r];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_entry;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// ----- sv/shef_back.sv -----
// Back end: tracked-source tables, sequential search, holdoff check, update.
// Depends on shef_pkg; takes beats from shef_queue.
module shef_back
  import shef_pkg::*;
#(
  parameter int unsigned TRACKED_PER_PROTO = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  input  shef_entry_t     head,
  input  logic            q_empty,
  output logic            pop,
  output shef_back_stat_t stat,
  output logic            out_strobe,
  output logic [1:0]      out_verdict
);

  localparam int unsigned ENTRIES = PROTO_COUNT * TRACKED_PER_PROTO;
  localparam int unsigned AW = $clog2(ENTRIES);
  localparam int unsigned SW = (TRACKED_PER_PROTO > 1) ? $clog2(TRACKED_PER_PROTO) : 1;
  localparam int unsigned CW = $clog2(TRACKED_PER_PROTO + 1);

  typedef enum logic [2:0] {
    ST_CLEAR  = 3'b001,
    ST_IDLE   = 3'b010,
    ST_SEARCH = 3'b100
  } back_state_t;

  // Tables
  logic [31:0] addr_mem [ENTRIES];
  logic [31:0] time_mem [ENTRIES];
  logic [31:0] rd_addr_q, rd_time_q;

  back_state_t        st_r, st_nxt;
  logic [AW-1:0]      clr_r, clr_nxt;
  logic [SW-1:0]      slot_r [PROTO_COUNT];
  logic [SW-1:0]      slot_nxt [PROTO_COUNT];
  logic [31:0]        src_r, src_nxt;
  logic [31:0]        now_r, now_nxt;
  logic [LIMIT_W-1:0] limit_r, limit_nxt;
  logic [1:0]         proto_r, proto_nxt;
  logic [AW-1:0]      base_r, base_nxt;
  logic [CW-1:0]      idx_r, idx_nxt;
  logic [SW-1:0]      cmp_idx_r, cmp_idx_nxt;
  logic               rd_pend_r, rd_pend_nxt;
  logic               out_strobe_r, out_strobe_nxt;
  logic [1:0]         out_verdict_r, out_verdict_nxt;

  logic               rd_en;
  logic [AW-1:0]      rd_idx;
  logic               we_time, we_addr;
  logic [AW-1:0]      w_idx;
  logic [31:0]        w_src, w_time;
  logic [31:0]        elapsed;
  logic [SW-1:0]      cur_slot;

  assign stat.clearing = (st_r == ST_CLEAR);
  assign out_strobe    = out_strobe_r;
  assign out_verdict   = out_verdict_r;
  assign elapsed       = now_r - rd_time_q;
  assign cur_slot      = slot_r[proto_r];

  // Memory ports: one write, one registered read
  always_ff @(posedge clk) begin
    if (we_addr) begin
      addr_mem[w_idx] <= w_src;
    end
    if (we_time) begin
      time_mem[w_idx] <= w_time;
    end
    if (rd_en) begin
      rd_addr_q <= addr_mem[rd_idx];
      rd_time_q <= time_mem[rd_idx];
    end
  end

  // Sequencer
  always_comb begin
    st_nxt          = st_r;
    clr_nxt         = clr_r;
    slot_nxt        = slot_r;
    src_nxt         = src_r;
    now_nxt         = now_r;
    limit_nxt       = limit_r;
    proto_nxt       = proto_r;
    base_nxt        = base_r;
    idx_nxt         = idx_r;
    cmp_idx_nxt     = cmp_idx_r;
    rd_pend_nxt     = rd_pend_r;
    out_strobe_nxt  = 1'b0;
    out_verdict_nxt = out_verdict_r;
    pop             = 1'b0;
    rd_en           = 1'b0;
    rd_idx          = base_r + AW'(idx_r[SW-1:0]);
    we_time         = 1'b0;
    we_addr         = 1'b0;
    w_idx           = clr_r;
    w_src           = '0;
    w_time          = '0;

    unique case (st_r)
      ST_CLEAR: begin
        // zero one entry per cycle after reset
        we_time = 1'b1;
        we_addr = 1'b1;
        if (clr_r == AW'(ENTRIES - 1)) begin
          st_nxt = ST_IDLE;
        end else begin
          clr_nxt = clr_r + 1'b1;
        end
      end

      ST_IDLE: begin
        if (!q_empty) begin
          pop = 1'b1;
          if (head.imm) begin
            out_strobe_nxt  = 1'b1;
            out_verdict_nxt = head.verdict;
          end else begin
            src_nxt     = head.src;
            now_nxt     = head.now;
            limit_nxt   = head.limit;
            proto_nxt   = head.proto;
            base_nxt    = AW'(head.proto) * AW'(TRACKED_PER_PROTO);
            idx_nxt     = '0;
            rd_pend_nxt = 1'b0;
            st_nxt      = ST_SEARCH;
          end
        end
      end

      ST_SEARCH: begin
        if (rd_pend_r && (rd_addr_q == src_r)) begin
          // first match: check elapsed time
          w_idx          = base_r + AW'(cmp_idx_r);
          w_time         = now_r;
          out_strobe_nxt = 1'b1;
          rd_pend_nxt    = 1'b0;
          st_nxt         = ST_IDLE;
          if (elapsed >= 32'(limit_r)) begin
            we_time         = 1'b1;
            out_verdict_nxt = VERDICT_LOG;
          end else begin
            out_verdict_nxt = VERDICT_HOLD;
          end
        end else if (rd_pend_r && (cmp_idx_r == SW'(TRACKED_PER_PROTO - 1))) begin
          // miss: replace round-robin slot
          we_time         = 1'b1;
          we_addr         = 1'b1;
          w_idx           = base_r + AW'(cur_slot);
          w_src           = src_r;
          w_time          = now_r;
          slot_nxt[proto_r] = (cur_slot == SW'(TRACKED_PER_PROTO - 1)) ?
                              '0 : cur_slot + 1'b1;
          out_strobe_nxt  = 1'b1;
          out_verdict_nxt = VERDICT_LOG;
          rd_pend_nxt     = 1'b0;
          st_nxt          = ST_IDLE;
        end else begin
          // issue the next read
          rd_en       = (idx_r != CW'(TRACKED_PER_PROTO));
          rd_pend_nxt = rd_en;
          if (rd_en) begin
            cmp_idx_nxt = idx_r[SW-1:0];
            idx_nxt     = idx_r + 1'b1;
          end
        end
      end

      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= ST_CLEAR;
      clr_r        <= '0;
      rd_pend_r    <= 1'b0;
      out_strobe_r <= 1'b0;
      for (int p = 0; p < PROTO_COUNT; p++) begin
        slot_r[p] <= '0;
      end
    end else begin
      st_r         <= st_nxt;
      clr_r        <= clr_nxt;
      rd_pend_r    <= rd_pend_nxt;
      out_strobe_r <= out_strobe_nxt;
      slot_r       <= slot_nxt;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    src_r         <= src_nxt;
    now_r         <= now_nxt;
    limit_r       <= limit_nxt;
    proto_r       <= proto_nxt;
    base_r        <= base_nxt;
    idx_r         <= idx_nxt;
    cmp_idx_r     <= cmp_idx_nxt;
    out_verdict_r <= out_verdict_nxt;
  end

endmodule

// ----- sv/source_holdoff_event_filter_core.sv -----
// Per-source event holdoff filter with broadcast/multicast drop.
// Dropped or untracked events skip the table search; the search for other events reads
// one entry per cycle from the tables (single read port).
// Throughput: one event per cycle without a search while busy is low; a search holds
// later events in the queue until it ends. Reset: synchronous; afterwards busy stays
// high while the tables are zeroed. Results cannot be stalled by the receiver.
module source_holdoff_event_filter_core
  import shef_pkg::*;
#(
  parameter int unsigned TRACKED_PER_PROTO = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_source_addr,
  input  logic [1:0]  in_proto_kind,
  input  logic [31:0] in_now_ms,
  output logic        out_strobe,
  output logic [1:0]  out_verdict,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  shef_entry_t     front_entry, q_head;
  shef_back_stat_t back_stat;
  logic            q_push, q_pop, q_empty, q_full;

  // Accept while the queue has room and the tables are ready
  assign busy   = back_stat.clearing || q_full;
  assign q_push = start && !busy;

  shef_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .source_addr (in_source_addr),
    .proto_kind  (in_proto_kind),
    .now_ms      (in_now_ms),
    .entry       (front_entry)
  );

  shef_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (front_entry),
    .pop        (q_pop),
    .head       (q_head),
    .empty      (q_empty),
    .full       (q_full)
  );

  shef_back #(
    .TRACKED_PER_PROTO (TRACKED_PER_PROTO)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .head        (q_head),
    .q_empty     (q_empty),
    .pop         (q_pop),
    .stat        (back_stat),
    .out_strobe  (out_strobe),
    .out_verdict (out_verdict)
  );

`ifndef SYNTH
  // No result while the tables are being cleared
  a_no_out_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    back_stat.clearing |-> !out_strobe)
    else $error("result during table clear");

  // Reset always starts a clearing pass
  a_busy_after_reset: assert property (@(posedge clk)
    !rst_n |=> busy)
    else $error("not busy after reset");

  // Back end only pops a non-empty queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("pop from empty queue");

  // Verdict code is always a defined one
  a_verdict_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_verdict == VERDICT_LOG || out_verdict == VERDICT_DROP ||
                    out_verdict == VERDICT_HOLD))
    else $error("undefined verdict");
`endif

endmodule
